>>> rtl/damped_comb_filter_macros.svh
// ----------------------------------------------------------------------------
// damped comb filter assertion macros
// clocked checks on i_clk, quiet while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef DAMPED_COMB_FILTER_MACROS_SVH
`define DAMPED_COMB_FILTER_MACROS_SVH

// consequent checked in the same cycle
`define DCF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define DCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// shared types and constants of the damped comb filter
// ----------------------------------------------------------------------------
package dcf_pkg;

    // field and register widths
    localparam int SAMPLE_BITS = 24;
    localparam int DELAY_CFG_W = 13;
    localparam int GAIN_W      = 16;
    localparam int DAMP_W      = 16;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int FRAC_W      = 15;

    // register reset values and limits
    localparam logic [DELAY_CFG_W-1:0] DELAY_RESET = 13'd480;
    localparam logic [DAMP_W-1:0]      DAMP_ONE    = 16'h8000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_FACTOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMB_MODE      = 2'd3;

    // filter modes, any other code runs the dual path
    localparam logic [MODE_W-1:0] MODE_FEEDFORWARD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DAMPED      = 2'd1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic    channel;
        t_sample in_sample;
    } t_in_item;

    typedef struct packed {
        logic    out_channel;
        t_sample out_sample;
    } t_out_item;

    // stage controls from the sequencer to the arithmetic unit
    typedef struct packed {
        logic                     ld_damp;
        logic                     ld_gain;
        logic [MODE_W-1:0]        mode;
        logic [DAMP_W-1:0]        damping;
        logic signed [GAIN_W-1:0] gain;
    } t_arith_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DAMP,
        ST_GAIN,
        ST_DONE
    } t_state;

endpackage

>>> rtl/damped_comb_filter.sv
// ----------------------------------------------------------------------------
// damped_comb_filter
// per-channel comb filter over a shared delay memory, with damped feedback
// ----------------------------------------------------------------------------
// result: registered in the output register when the item is written back
// sequence: one sample at a time (memory read, damping multiply, gain
//   multiply, write back); the write back waits while the output register is full
// reset: registers to defaults, write positions, fill counts and previous outputs
//   cleared; the delay memory is not swept, taps not yet written read as zero
`include "damped_comb_filter_macros.svh"

module damped_comb_filter #(
    parameter int MAX_DELAY = 4096,
    parameter int CHANNELS  = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dcf_pkg::t_in_item                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dcf_pkg::t_out_item                  o_out,
    input  logic                                i_cfg_wr_en,
    input  logic [dcf_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [dcf_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import dcf_pkg::*;

    localparam int AW    = $clog2(MAX_DELAY);
    localparam int DW    = $clog2(MAX_DELAY + 1);
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * MAX_DELAY;
    localparam int MW    = $clog2(DEPTH);

    // configuration registers
    logic [DELAY_CFG_W-1:0]   r_delay_samples;
    logic signed [GAIN_W-1:0] r_feedback_gain;
    logic [DAMP_W-1:0]        r_damping_factor;
    logic [MODE_W-1:0]        r_comb_mode;

    // per-channel state
    logic [AW-1:0] r_wp   [CHANNELS];
    logic [DW-1:0] r_fill [CHANNELS];
    t_sample       r_prev [CHANNELS];

    // item in flight
    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_ch;
    logic          r_ch_field;
    t_sample       r_x;
    logic [AW-1:0] r_wp_cur;
    logic          r_hit;

    // output register
    t_out_item     r_out;
    logic          r_out_valid;

    logic          in_accept;
    logic          commit_item;
    logic [CW-1:0] in_ch;
    logic [AW-1:0] wp_in;
    logic [DW-1:0] fill_in;
    logic [DW-1:0] d_eff;
    logic [DW:0]   wp_x;
    logic [DW:0]   d_x;
    logic [DW:0]   rp_ext;
    logic [MW-1:0] rd_addr;
    logic [MW-1:0] wr_addr;
    logic [AW-1:0] wp_next;
    logic [DAMP_W-1:0] dmp_eff;
    t_sample       rd_data;
    t_sample       delayed;
    t_sample       y;
    t_arith_ctl    arith_ctl;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_samples  <= DELAY_RESET;
            r_feedback_gain  <= '0;
            r_damping_factor <= '0;
            r_comb_mode      <= MODE_FEEDFORWARD;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_DELAY_SAMPLES:  r_delay_samples  <= i_cfg_wdata[DELAY_CFG_W-1:0];
                REG_FEEDBACK_GAIN:  r_feedback_gain  <= i_cfg_wdata[GAIN_W-1:0];
                REG_DAMPING_FACTOR: r_damping_factor <= i_cfg_wdata[DAMP_W-1:0];
                REG_COMB_MODE:      r_comb_mode      <= i_cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // channel select, out of range channels fold onto the last one
    always_comb begin
        if (int'(i_in.channel) < CHANNELS) begin
            in_ch = CW'(i_in.channel);
        end else begin
            in_ch = CW'(CHANNELS - 1);
        end
    end

    assign wp_in   = r_wp[in_ch];
    assign fill_in = r_fill[in_ch];

    // delay clamped to one .. MAX_DELAY
    always_comb begin
        if (r_delay_samples == '0) begin
            d_eff = DW'(1);
        end else if (32'(r_delay_samples) > 32'(MAX_DELAY)) begin
            d_eff = DW'(MAX_DELAY);
        end else begin
            d_eff = DW'(r_delay_samples);
        end
    end

    // tap position behind the write position, wrapping in the channel block
    assign wp_x   = (DW + 1)'(wp_in);
    assign d_x    = (DW + 1)'(d_eff);
    assign rp_ext = (wp_x >= d_x) ? (wp_x - d_x) : (wp_x + (DW + 1)'(MAX_DELAY) - d_x);
    assign rd_addr = MW'(in_ch) * MW'(MAX_DELAY) + MW'(rp_ext[AW-1:0]);
    assign wr_addr = MW'(r_ch) * MW'(MAX_DELAY) + MW'(r_wp_cur);
    assign wp_next = (r_wp_cur == AW'(MAX_DELAY - 1)) ? '0 : r_wp_cur + AW'(1);

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_DAMP;
            ST_DAMP: n_state = ST_GAIN;
            ST_GAIN: n_state = ST_DONE;
            ST_DONE: if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: stage controls
    always_comb begin
        o_in_ready  = 1'b0;
        commit_item = 1'b0;
        arith_ctl.ld_damp = 1'b0;
        arith_ctl.ld_gain = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_DAMP: arith_ctl.ld_damp = 1'b1;
            ST_GAIN: arith_ctl.ld_gain = 1'b1;
            ST_DONE: commit_item = !r_out_valid || i_out_ready;
            default: ;
        endcase
        arith_ctl.mode    = r_comb_mode;
        arith_ctl.damping = dmp_eff;
        arith_ctl.gain    = r_feedback_gain;
    end

    assign in_accept = i_in_valid && o_in_ready;
    assign dmp_eff   = (r_damping_factor > DAMP_ONE) ? DAMP_ONE : r_damping_factor;

    // capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ch       <= in_ch;
            r_ch_field <= i_in.channel;
            r_x        <= i_in.in_sample;
            r_wp_cur   <= wp_in;
            r_hit      <= rp_ext < (DW + 1)'(fill_in);
        end
    end

    dcf_delay_ram #(
        .DEPTH (DEPTH),
        .AW    (MW)
    ) u_delay_ram (
        .i_clk     (i_clk),
        .i_wr_en   (commit_item),
        .i_wr_addr (wr_addr),
        .i_wr_data (y),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // taps never written read as zero
    assign delayed = r_hit ? rd_data : '0;

    dcf_arith u_arith (
        .i_clk     (i_clk),
        .i_ctl     (arith_ctl),
        .i_delayed (delayed),
        .i_prev    (r_prev[r_ch]),
        .i_x       (r_x),
        .o_y       (y)
    );

    // per-channel state update on write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_wp[i]   <= '0;
                r_fill[i] <= '0;
                r_prev[i] <= '0;
            end
        end else if (commit_item) begin
            r_wp[r_ch] <= wp_next;
            if (r_fill[r_ch] != DW'(MAX_DELAY)) begin
                r_fill[r_ch] <= r_fill[r_ch] + DW'(1);
            end
            if (r_comb_mode != MODE_FEEDFORWARD) begin
                r_prev[r_ch] <= y;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit_item) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_item) begin
            r_out.out_channel <= r_ch_field;
            r_out.out_sample  <= y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks
    `DCF_ASSERT_NEXT(a_accept_starts_item, in_accept, r_state == ST_DAMP, "accepted transaction not started")
    `DCF_ASSERT_NEXT(a_commit_fills_output, commit_item, r_out_valid, "write back left output empty")
    `DCF_ASSERT_NEXT(a_wp_advances, commit_item, r_wp[$past(r_ch)] != $past(r_wp_cur), "write position stuck")

endmodule

>>> rtl/dcf_delay_ram.sv
// ----------------------------------------------------------------------------
// dcf_delay_ram
// delay line storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module dcf_delay_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  dcf_pkg::t_sample i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output dcf_pkg::t_sample o_rd_data
);
    import dcf_pkg::*;

    t_sample r_mem [DEPTH];
    t_sample r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/dcf_arith.sv
// ----------------------------------------------------------------------------
// dcf_arith
// damping blend, gain multiply, rounding and saturation
// ----------------------------------------------------------------------------
module dcf_arith (
    input  logic                i_clk,
    input  dcf_pkg::t_arith_ctl i_ctl,
    input  dcf_pkg::t_sample    i_delayed,
    input  dcf_pkg::t_sample    i_prev,
    input  dcf_pkg::t_sample    i_x,
    output dcf_pkg::t_sample    o_y
);
    import dcf_pkg::*;

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int DMP_W  = DAMP_W + 2;
    localparam int PD_W   = DIFF_W + DMP_W;
    localparam int OP_W   = SAMPLE_BITS + 2;
    localparam int PG_W   = OP_W + GAIN_W;
    localparam int Y_W    = SAMPLE_BITS + 3;

    localparam logic signed [PD_W-1:0] HALF_D    = PD_W'(1) << (FRAC_W - 1);
    localparam logic signed [PG_W-1:0] HALF_G    = PG_W'(1) << (FRAC_W - 1);
    localparam logic signed [PG_W-1:0] HALF_DUAL = PG_W'(1) << FRAC_W;
    localparam logic signed [Y_W-1:0]  SAT_HI    =
        {{(Y_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [Y_W-1:0]  SAT_LO    = ~SAT_HI;

    logic signed [DIFF_W-1:0] diff;
    logic signed [DMP_W-1:0]  dmp_s;
    logic signed [PD_W-1:0]   prod_d;
    logic signed [PD_W-1:0]   r_prod_d;
    t_sample                  r_delayed;
    logic signed [PD_W-1:0]   sum_d;
    logic signed [DIFF_W-1:0] damp_step;
    logic signed [DIFF_W-1:0] damped;
    logic signed [OP_W-1:0]   gain_op;
    logic signed [PG_W-1:0]   prod_g;
    logic signed [PG_W-1:0]   r_prod_g;
    logic                     r_dual;
    logic signed [PG_W-1:0]   sum_g;
    logic signed [Y_W-1:0]    scaled;
    logic signed [Y_W-1:0]    total;

    // damping stage: (prev - delayed) * damping
    assign diff   = DIFF_W'(i_prev) - DIFF_W'(i_delayed);
    assign dmp_s  = {2'b00, i_ctl.damping};
    assign prod_d = PD_W'(diff) * PD_W'(dmp_s);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_damp) begin
            r_prod_d  <= prod_d;
            r_delayed <= i_delayed;
        end
    end

    // damped value = delayed + round(step / 2^15), stays between prev and delayed
    assign sum_d     = r_prod_d + HALF_D;
    assign damp_step = DIFF_W'(sum_d >>> FRAC_W);
    assign damped    = DIFF_W'(r_delayed) + damp_step;

    // gain operand by mode
    always_comb begin
        case (i_ctl.mode)
            MODE_FEEDFORWARD: gain_op = OP_W'(r_delayed);
            MODE_DAMPED:      gain_op = OP_W'(damped);
            default:          gain_op = OP_W'(r_delayed) + OP_W'(damped);
        endcase
    end

    assign prod_g = PG_W'(gain_op) * PG_W'(i_ctl.gain);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_gain) begin
            r_prod_g <= prod_g;
            r_dual   <= (i_ctl.mode != MODE_FEEDFORWARD) && (i_ctl.mode != MODE_DAMPED);
        end
    end

    // round, the dual path takes one more bit for the one half
    always_comb begin
        if (r_dual) begin
            sum_g  = r_prod_g + HALF_DUAL;
            scaled = Y_W'(sum_g >>> (FRAC_W + 1));
        end else begin
            sum_g  = r_prod_g + HALF_G;
            scaled = Y_W'(sum_g >>> FRAC_W);
        end
    end

    // add input and saturate
    assign total = Y_W'(i_x) + scaled;

    always_comb begin
        if (total > SAT_HI) begin
            o_y = SAMPLE_BITS'(SAT_HI);
        end else if (total < SAT_LO) begin
            o_y = SAMPLE_BITS'(SAT_LO);
        end else begin
            o_y = SAMPLE_BITS'(total);
        end
    end

endmodule
